/* hdl/fsf_pkg.sv */
`default_nettype none
package fsf_pkg;

  localparam int MAX_TAPS = 256;
  localparam int IDX_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int ACC_W    = 32 + IDX_W;
  localparam int CFG_W    = 9;
  localparam int IDX_IN_W = 8;
  localparam int SMP_W    = 16;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH,
    S_DONE
  } fsf_state_t;

  typedef struct packed {
    logic coef_wr;
    logic start;
    logic issue;
    logic finish;
  } fsf_cmd_t;

  typedef struct packed {
    logic taps_zero;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fsf_stat_t;

endpackage
`default_nettype wire

/* hdl/fir_filter_saturating.sv */
`default_nettype none
// channel | dir | handshake           | payload
// in_     | in  | in_tvalid/in_tready | tdata: coeff_index, value; tuser: command;
//         |     |                     | tlast: last_in_block
// out_    | out | out_tvalid/out_tready | tdata: filtered_sample; tuser: saturated;
//         |     |                     | tlast: last_of_block
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data: tap_count
//
// A coefficient item is written from the idle state. A sample item runs min(tap_count, 256)
// taps (none with zero taps) through one shared multiply-accumulate at one tap per cycle,
// then the read and multiply stages drain into the accumulator and the sum is rounded.
// Reset is synchronous; coefficients and history read as zero from reset on
// through valid bits and a fill count, so no clearing pass is needed.
// A new item is taken while the previous result waits in the output register;
// a stalled output only holds the block once the next result is ready.
module fir_filter_saturating (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] coeff_index, [23:8] value
  input  wire logic        in_tuser,   // [0] command
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] filtered_sample
  output logic             out_tuser,  // [0] saturated
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);
  import fsf_pkg::*;

  fsf_cmd_t                cmd;
  fsf_stat_t               stat;
  logic signed [SMP_W-1:0] filtered_sample;

  assign cfg_ready = 1'b1;

  fsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  fsf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .coeff_index     (in_tdata[7:0]),
    .value           (in_tdata[23:8]),
    .last_in_block   (in_tlast),
    .cfg_wr          (cfg_valid),
    .cfg_value       (cfg_data),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .filtered_sample (filtered_sample),
    .last_of_block   (out_tlast),
    .saturated       (out_tuser)
  );

  assign out_tdata = filtered_sample;

endmodule
`default_nettype wire

/* hdl/fsf_ctrl.sv */
`default_nettype none
module fsf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_kind,
  input  wire fsf_pkg::fsf_stat_t stat,
  output fsf_pkg::fsf_cmd_t      cmd
);
  import fsf_pkg::*;

  fsf_state_t state_r, state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    accept      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        accept    = in_tvalid;
        if (accept && in_kind == CMD_COEF) begin
          cmd.coef_wr = 1'b1;
        end
        if (accept && in_kind == CMD_SAMPLE) begin
          cmd.start = 1'b1;
          state_nxt = stat.taps_zero ? S_FLUSH : S_RUN;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        if (stat.last_tap) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // wait for the read and multiply stages to empty into the accumulator
        if (!stat.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/fsf_datapath.sv */
`default_nettype none
module fsf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fsf_pkg::fsf_cmd_t             cmd,
  output fsf_pkg::fsf_stat_t                 stat,
  input  wire logic [fsf_pkg::IDX_IN_W-1:0]  coeff_index,
  input  wire logic signed [fsf_pkg::SMP_W-1:0] value,
  input  wire logic                          last_in_block,
  input  wire logic                          cfg_wr,
  input  wire logic [fsf_pkg::CFG_W-1:0]     cfg_value,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic signed [fsf_pkg::SMP_W-1:0]   filtered_sample,
  output logic                               last_of_block,
  output logic                               saturated
);
  import fsf_pkg::*;

  localparam logic signed [ACC_W:0] HALF_LSB = (ACC_W+1)'(16384);
  localparam logic signed [ACC_W:0] UPPER    = (ACC_W+1)'(32767 * 32768);
  localparam logic signed [ACC_W:0] LOWER    = -((ACC_W+1)'(32768 * 32768));

  logic signed [SMP_W-1:0] coef_mem [MAX_TAPS];
  logic signed [SMP_W-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     coef_vld_r;

  logic [CFG_W-1:0]        tap_count_r;
  logic [CNT_W-1:0]        taps_eff;
  logic [IDX_W-1:0]        idx_r, head_r, hslot;
  logic [CNT_W-1:0]        fill_r;
  logic                    last_r;
  logic                    b_act_r, b_ok_r, c_act_r;
  logic signed [SMP_W-1:0] coef_q_r, hist_q_r;
  logic                    cval_r;
  logic signed [31:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    tap_live;

  logic signed [ACC_W:0]   rnd;
  logic signed [ACC_W:0]   quo;
  logic signed [SMP_W-1:0] y_val;
  logic                    y_sat;

  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_data_r;
  logic                    out_last_r, out_sat_r;

  // tap count is clamped to the table size
  always_comb begin
    if (int'(tap_count_r) > MAX_TAPS) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = CNT_W'(tap_count_r);
    end
  end

  // history slot of tap idx: head - idx, wrapping around the table
  always_comb begin
    if (head_r >= idx_r) begin
      hslot = head_r - idx_r;
    end else begin
      hslot = IDX_W'(int'(head_r) + MAX_TAPS - int'(idx_r));
    end
  end

  // taps older than the block start read as zero
  assign tap_live = CNT_W'(idx_r) < fill_r;

  assign stat.taps_zero = (taps_eff == '0);
  assign stat.last_tap  = (CNT_W'(idx_r) == taps_eff - CNT_W'(1));
  assign stat.pipe_busy = b_act_r | c_act_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && int'(coeff_index) < MAX_TAPS) begin
      coef_mem[IDX_W'(coeff_index)] <= value;
    end
    coef_q_r <= coef_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hist_mem[head_r] <= value;
    end
    hist_q_r <= hist_mem[hslot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= CFG_W'(256);
      coef_vld_r  <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      last_r      <= 1'b0;
      b_act_r     <= 1'b0;
      c_act_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tap_count_r <= cfg_value;
      end
      if (cmd.coef_wr && int'(coeff_index) < MAX_TAPS) begin
        coef_vld_r[IDX_W'(coeff_index)] <= 1'b1;
      end
      if (cmd.start) begin
        idx_r  <= '0;
        last_r <= last_in_block;
        if (fill_r != CNT_W'(MAX_TAPS)) begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end else if (cmd.issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      b_act_r <= cmd.issue;
      c_act_r <= b_act_r;
      if (cmd.finish) begin
        if (last_r) begin
          head_r <= '0;
          fill_r <= '0;
        end else if (int'(head_r) == MAX_TAPS - 1) begin
          head_r <= '0;
        end else begin
          head_r <= head_r + IDX_W'(1);
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // multiply-accumulate pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    b_ok_r <= tap_live;
    cval_r <= coef_vld_r[idx_r];
    if (b_act_r && b_ok_r && cval_r) begin
      prod_r <= coef_q_r * hist_q_r;
    end else begin
      prod_r <= '0;
    end
    if (cmd.start) begin
      acc_r <= '0;
    end else if (c_act_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // add half an LSB, clamp, then truncate toward zero
  always_comb begin
    rnd = (ACC_W+1)'(acc_r) + HALF_LSB;
    quo = rnd >>> 15;
    if (rnd[ACC_W] && rnd[14:0] != '0) begin
      quo = quo + (ACC_W+1)'(1);
    end
    if (rnd > UPPER) begin
      y_val = 16'sh7fff;
      y_sat = 1'b1;
    end else if (rnd < LOWER) begin
      y_val = 16'sh8000;
      y_sat = 1'b1;
    end else begin
      y_val = quo[SMP_W-1:0];
      y_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= y_val;
      out_last_r <= last_r;
      out_sat_r  <= y_sat;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign filtered_sample = out_data_r;
  assign last_of_block   = out_last_r;
  assign saturated       = out_sat_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before it was taken");

  a_pipe_empty_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (!b_act_r && !c_act_r))
    else $error("new sample started with taps still in flight");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (CNT_W'(idx_r) < taps_eff))
    else $error("tap issued beyond the active tap count");

  a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && last_r) |=> (fill_r == '0 && head_r == '0))
    else $error("history not cleared after block end");

endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  import fsf_pkg::*;

  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     SETTLE_CYCLES = 16;
  localparam longint SAT_HIGH      = 64'sd32767 * 64'sd32768;
  localparam longint SAT_LOW       = -64'sd32768 * 64'sd32768;
  localparam longint HALF_LSB      = 64'sd16384;

  typedef struct {
    logic    cmd;
    bit [7:0] idx;
    shortint val;
    bit      last;
  } fir_item_t;

  typedef struct {
    shortint y;
    bit      last;
    bit      sat;
  } fir_output_t;

  class fir_scoreboard;
    shortint     coef_table[MAX_TAPS];
    shortint     history[MAX_TAPS];
    int          head;
    int          tap_count;
    fir_output_t expected_q[$];
    int          errors;

    function new();
      foreach (coef_table[i]) coef_table[i] = 0;
      foreach (history[i]) history[i] = 0;
      head      = 0;
      tap_count = MAX_TAPS;
      errors    = 0;
    endfunction

    function void load_taps(int v);
      tap_count = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Models one accepted item; only a sample queues the output it should make.
    function void note_input(fir_item_t it);
      longint      acc;
      longint      t;
      int          n;
      fir_output_t r;
      acc = 0;
      if (it.cmd == CMD_COEF) begin
        coef_table[it.idx] = it.val;
        return;
      end
      history[head] = it.val;
      n = (tap_count > MAX_TAPS) ? MAX_TAPS : tap_count;
      for (int i = 0; i < n; i++)
        acc += longint'(coef_table[i]) * longint'(history[(head + MAX_TAPS - i) % MAX_TAPS]);
      t      = acc + HALF_LSB;
      r.last = it.last;
      r.sat  = 1'b1;
      if (t > SAT_HIGH) begin
        r.y = 16'sh7fff;
      end else if (t < SAT_LOW) begin
        r.y = 16'sh8000;
      end else begin
        r.y   = shortint'(t / 32768);   // truncates toward zero
        r.sat = 1'b0;
      end
      expected_q.push_back(r);
      head = (head + 1) % MAX_TAPS;
      if (it.last) begin
        foreach (history[i]) history[i] = 0;
        head = 0;
      end
    endfunction

    function void check_result(logic [15:0] y, logic last, logic sat);
      fir_output_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output item: y=%0d last=%b sat=%b", $signed(y), last, sat);
        return;
      end
      e = expected_q.pop_front();
      if (y !== e.y || last !== e.last || sat !== e.sat) begin
        errors++;
        if (errors <= 10)
          $display("output mismatch: expected y=%0d last=%b sat=%b, got y=%0d last=%b sat=%b",
                   e.y, e.last, e.sat, $signed(y), last, sat);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int cycle_count   = 0;

  fir_scoreboard filt_sb = new();

  fir_filter_saturating u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      filt_sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  function automatic fir_item_t coef(bit [7:0] idx, shortint val, bit last);
    fir_item_t it;
    it.cmd  = CMD_COEF;
    it.idx  = idx;
    it.val  = val;
    it.last = last;
    return it;
  endfunction

  function automatic fir_item_t smp(shortint val, bit last);
    fir_item_t it;
    it.cmd  = CMD_SAMPLE;
    it.idx  = 8'($urandom);
    it.val  = val;
    it.last = last;
    return it;
  endfunction

  function automatic fir_item_t make_item(int taps);
    fir_item_t it;
    int        span;
    int        pick;
    span = (taps > MAX_TAPS) ? MAX_TAPS : taps;
    pick = $urandom_range(9);
    if (pick == 0)
      it.val = 16'sh7fff;
    else if (pick == 1)
      it.val = 16'sh8000;
    else if (pick < 4)
      it.val = shortint'(int'($urandom_range(512)) - 256);
    else
      it.val = shortint'($urandom);
    if ($urandom_range(99) < 60) begin
      it.cmd  = CMD_SAMPLE;
      it.idx  = 8'($urandom);
      it.last = ($urandom_range(15) == 0);
    end else begin
      it.cmd  = CMD_COEF;
      // keep most coefficients in the active window and some of them modest
      if (span > 0 && $urandom_range(99) < 75)
        it.idx = 8'($urandom_range(span - 1));
      else
        it.idx = 8'($urandom);
      if ($urandom_range(1))
        it.val = it.val >>> $urandom_range(1, 8);
      it.last = 1'($urandom_range(1));
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(fir_item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.val, it.idx};
    in_tuser  <= it.cmd;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    filt_sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (filt_sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_taps(logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    filt_sb.load_taps(int'(v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(int m);
    case (m)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 54; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 54; end
      default: begin send_idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  initial begin
    int taps_plan[8];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    taps_plan = '{256, 4, 16, 1, 300, 0, 33, 511};
    taps_plan[5] = $urandom_range(2, 40);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full tap count from reset; empty coefficient table gives zero
    send_item(smp(1234, 0));
    send_item(coef(0, 16'sh7fff, 1));   // block-end flag is ignored on a coefficient
    send_item(coef(255, 16'sh8000, 0));
    send_item(smp(16'sh7fff, 0));
    send_item(smp(16'sh8000, 1));
    settle();

    // single tap: exact x.5 above the top clamps, and the most negative product
    write_taps(9'd1);
    send_item(coef(0, 16'sh8000, 0));
    send_item(smp(-32767, 0));
    send_item(smp(16'sh8000, 0));
    send_item(coef(0, 16'sh7fff, 0));
    send_item(smp(16'sh8000, 1));
    settle();

    // two full-scale taps drive the sum below the bottom limit
    write_taps(9'd2);
    send_item(coef(0, 16'sh8000, 0));
    send_item(coef(1, 16'sh8000, 0));
    send_item(smp(16'sh7fff, 0));
    send_item(smp(16'sh7fff, 1));
    settle();

    write_taps(9'd0);
    send_item(smp(100, 1));
    settle();

    // above the table size the count is capped
    write_taps(9'd511);
    send_item(smp(16'sh8000, 0));
    send_item(smp(16'sh7fff, 1));

    foreach (taps_plan[p]) begin
      settle();
      write_taps(taps_plan[p][8:0]);
      set_mode(p % 4);
      repeat (48) send_item(make_item(taps_plan[p]));
    end
    settle();

    if (filt_sb.errors == 0 && filt_sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

/* fir_filter_saturating.f */
hdl/fsf_pkg.sv
hdl/fsf_ctrl.sv
hdl/fsf_datapath.sv
hdl/fir_filter_saturating.sv
dv/tb.sv
